// ----- hw/rtl/psna_pkg.sv -----
// ----------------------------------------------------------------------------
// psna_pkg
// Shared constants, state codes and control/status types of the
// periodic-server job assignment block.
// ----------------------------------------------------------------------------
package psna_pkg;

    localparam int MAX_SERVERS_DEF = 1024;
    localparam int TIME_BITS_DEF   = 52;
    localparam int PERIOD_W        = 20;
    localparam int POS_W           = 32;
    localparam int SIDX_W          = 11;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MID,
        ST_RD,
        ST_DIVST,
        ST_DIVW,
        ST_ACC,
        ST_CHK,
        ST_REMI,
        ST_SCANI,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_REMOVE,
        PH_SCAN
    } phase_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_START,
        OP_MID,
        OP_RD,
        OP_DIV,
        OP_ACC_S,
        OP_STEP,
        OP_REM_INIT,
        OP_ACC_R,
        OP_SCAN_INIT,
        OP_ACC_SC,
        OP_FINISH
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic triv;
        logic lo_lt_hi;
        logic idx_end;
        logic enough;
        logic rem_zero;
        logic found;
        logic div_done;
        logic out_busy;
    } status_t;

endpackage

// ----- hw/rtl/psna_req_if.sv -----
// ----------------------------------------------------------------------------
// psna_req_if
// Input channel: load a server period or query a job position.
// ----------------------------------------------------------------------------
interface psna_req_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [psna_pkg::PERIOD_W-1:0] period;
    logic [psna_pkg::POS_W-1:0]    position;

    modport source (output valid, kind, period, position, input ready);
    modport sink   (input valid, kind, period, position, output ready);
endinterface

// ----- hw/rtl/psna_rsp_if.sv -----
// ----------------------------------------------------------------------------
// psna_rsp_if
// Output channel: server index and overflow flag of one query.
// ----------------------------------------------------------------------------
interface psna_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [psna_pkg::SIDX_W-1:0] server_index;
    logic                        overflow;

    modport source (output valid, server_index, overflow, input ready);
    modport sink   (input valid, server_index, overflow, output ready);
endinterface

// ----- hw/rtl/psna_div.sv -----
// ----------------------------------------------------------------------------
// psna_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psna_div #(
    parameter int TIME_BITS = psna_pkg::TIME_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [TIME_BITS-1:0]          dividend,
    input  logic [psna_pkg::PERIOD_W-1:0] divisor,
    output logic [TIME_BITS-1:0]          quot,
    output logic [psna_pkg::PERIOD_W-1:0] rem,
    output logic                          done
);
    localparam int DW = psna_pkg::PERIOD_W;
    localparam int CW = $clog2(TIME_BITS + 1);

    logic [TIME_BITS-1:0] q_reg, q_next;
    logic [DW-1:0]        r_reg, r_next;
    logic [DW-1:0]        d_reg, d_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic [DW:0]          trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {r_reg, q_reg[TIME_BITS-1]};
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = CW'(TIME_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = DW'(trial - {1'b0, d_reg});
                q_next = {q_reg[TIME_BITS-2:0], 1'b1};
            end
            else
            begin
                r_next = trial[DW-1:0];
                q_next = {q_reg[TIME_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign quot = q_reg;
    assign rem  = r_reg;
    assign done = !busy_reg && !start;
endmodule

// ----- hw/rtl/psna_ctrl.sv -----
// ----------------------------------------------------------------------------
// psna_ctrl
// Sequencer: time search, removal pass and server scan for each query.
// ----------------------------------------------------------------------------
module psna_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_kind,
    output logic                req_ready,
    input  psna_pkg::status_t   st,
    output psna_pkg::cmd_t      cmd
);
    psna_pkg::state_t state_reg, state_next;
    psna_pkg::phase_t ph_reg, ph_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= psna_pkg::ST_IDLE;
            ph_reg    <= psna_pkg::PH_SEARCH;
        end
        else
        begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ph_next    = ph_reg;
        case (state_reg)
            psna_pkg::ST_IDLE:
                if (req_valid && req_kind)
                    state_next = psna_pkg::ST_MID;
            psna_pkg::ST_MID:
                if (st.triv)
                    state_next = psna_pkg::ST_DONE;
                else if (st.lo_lt_hi)
                begin
                    state_next = psna_pkg::ST_RD;
                    ph_next    = psna_pkg::PH_SEARCH;
                end
                else
                    state_next = psna_pkg::ST_REMI;
            psna_pkg::ST_REMI:
            begin
                state_next = psna_pkg::ST_RD;
                ph_next    = psna_pkg::PH_REMOVE;
            end
            psna_pkg::ST_SCANI:
            begin
                state_next = psna_pkg::ST_RD;
                ph_next    = psna_pkg::PH_SCAN;
            end
            psna_pkg::ST_RD:    state_next = psna_pkg::ST_DIVST;
            psna_pkg::ST_DIVST: state_next = psna_pkg::ST_DIVW;
            psna_pkg::ST_DIVW:
                if (st.div_done)
                    state_next = psna_pkg::ST_ACC;
            psna_pkg::ST_ACC:   state_next = psna_pkg::ST_CHK;
            psna_pkg::ST_CHK:
                case (ph_reg)
                    psna_pkg::PH_SEARCH:
                        if (st.enough || st.idx_end)
                            state_next = psna_pkg::ST_MID;
                        else
                            state_next = psna_pkg::ST_RD;
                    psna_pkg::PH_REMOVE:
                        if (!st.idx_end)
                            state_next = psna_pkg::ST_RD;
                        else if (st.rem_zero)
                            state_next = psna_pkg::ST_DONE;
                        else
                            state_next = psna_pkg::ST_SCANI;
                    default:
                        if (st.found || st.idx_end)
                            state_next = psna_pkg::ST_DONE;
                        else
                            state_next = psna_pkg::ST_RD;
                endcase
            psna_pkg::ST_DONE:
                if (!st.out_busy)
                    state_next = psna_pkg::ST_IDLE;
            default:
                state_next = psna_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op    = psna_pkg::OP_NONE;
        req_ready = 1'b0;
        case (state_reg)
            psna_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                    cmd.op = req_kind ? psna_pkg::OP_START : psna_pkg::OP_LOAD;
            end
            psna_pkg::ST_MID:
                if (!st.triv && st.lo_lt_hi)
                    cmd.op = psna_pkg::OP_MID;
            psna_pkg::ST_REMI:  cmd.op = psna_pkg::OP_REM_INIT;
            psna_pkg::ST_SCANI: cmd.op = psna_pkg::OP_SCAN_INIT;
            psna_pkg::ST_RD:    cmd.op = psna_pkg::OP_RD;
            psna_pkg::ST_DIVST: cmd.op = psna_pkg::OP_DIV;
            psna_pkg::ST_ACC:
                case (ph_reg)
                    psna_pkg::PH_SEARCH: cmd.op = psna_pkg::OP_ACC_S;
                    psna_pkg::PH_REMOVE: cmd.op = psna_pkg::OP_ACC_R;
                    default:             cmd.op = psna_pkg::OP_ACC_SC;
                endcase
            psna_pkg::ST_CHK:
                if (ph_reg == psna_pkg::PH_SEARCH && (st.enough || st.idx_end))
                    cmd.op = psna_pkg::OP_STEP;
            psna_pkg::ST_DONE:
                if (!st.out_busy)
                    cmd.op = psna_pkg::OP_FINISH;
            default:
                cmd.op = psna_pkg::OP_NONE;
        endcase
    end
endmodule

// ----- hw/rtl/psna_dp.sv -----
// ----------------------------------------------------------------------------
// psna_dp
// Datapath: period memory, search bounds, running sums, divider, result
// register.
// ----------------------------------------------------------------------------
module psna_dp #(
    parameter int MAX_SERVERS = psna_pkg::MAX_SERVERS_DEF,
    parameter int TIME_BITS   = psna_pkg::TIME_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  psna_pkg::cmd_t                cmd,
    output psna_pkg::status_t             st,
    input  logic [psna_pkg::PERIOD_W-1:0] req_period,
    input  logic [psna_pkg::POS_W-1:0]    req_position,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic [psna_pkg::SIDX_W-1:0]   rsp_server_index,
    output logic                          rsp_overflow
);
    localparam int DW = psna_pkg::PERIOD_W;
    localparam int PW = psna_pkg::POS_W;
    localparam int AW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int CW = $clog2(MAX_SERVERS + 1);
    localparam int TW = ((TIME_BITS > PW) ? TIME_BITS : PW) + 1;

    logic [DW-1:0] mem [MAX_SERVERS];
    logic [DW-1:0] rd_reg;

    logic [CW-1:0]        count_reg;
    logic                 drop_reg;
    logic [PW-1:0]        need_reg;
    logic [TIME_BITS-1:0] lo_reg, hi_reg, t_reg;
    logic [TW-1:0]        total_reg;
    logic [PW-1:0]        rem_reg;
    logic [CW-1:0]        idx_reg;
    logic                 found_reg;
    logic [CW-1:0]        ans_reg;
    logic                 out_valid_reg;
    logic [psna_pkg::SIDX_W-1:0] out_idx_reg;
    logic                 out_ovf_reg;

    logic [TIME_BITS-1:0] quot;
    logic [DW-1:0]        drem;
    logic                 div_done;
    logic [DW-1:0]        divisor;
    logic [TIME_BITS-1:0] mid;
    logic [TW-1:0]        prior_cnt;

    // a zero period behaves as one
    assign divisor   = (rd_reg == '0) ? DW'(1) : rd_reg;
    assign mid       = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign prior_cnt = TW'(quot) + TW'(drem != '0);

    psna_div #(.TIME_BITS(TIME_BITS)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.op == psna_pkg::OP_DIV),
        .dividend (t_reg),
        .divisor  (divisor),
        .quot     (quot),
        .rem      (drem),
        .done     (div_done)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.op == psna_pkg::OP_LOAD && count_reg < CW'(MAX_SERVERS))
            mem[count_reg[AW-1:0]] <= req_period;
        if (cmd.op == psna_pkg::OP_RD)
            rd_reg <= mem[idx_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && rsp_ready)
                out_valid_reg <= 1'b0;
            case (cmd.op)
                psna_pkg::OP_LOAD:
                    if (count_reg < CW'(MAX_SERVERS))
                        count_reg <= count_reg + 1'b1;
                    else
                        drop_reg <= 1'b1;
                psna_pkg::OP_START:
                    found_reg <= 1'b0;
                psna_pkg::OP_ACC_SC:
                    if (drem == '0 && rem_reg == PW'(1))
                        found_reg <= 1'b1;
                psna_pkg::OP_FINISH:
                begin
                    out_valid_reg <= 1'b1;
                    count_reg     <= '0;
                    drop_reg      <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            psna_pkg::OP_START:
            begin
                need_reg <= req_position;
                lo_reg   <= '0;
                hi_reg   <= '1;
                ans_reg  <= '0;
            end
            psna_pkg::OP_MID:
            begin
                t_reg     <= mid;
                total_reg <= '0;
                idx_reg   <= '0;
            end
            psna_pkg::OP_ACC_S:
            begin
                total_reg <= total_reg + TW'(quot) + TW'(1);
                idx_reg   <= idx_reg + 1'b1;
            end
            psna_pkg::OP_STEP:
                if (total_reg >= TW'(need_reg))
                    hi_reg <= t_reg;
                else
                    lo_reg <= t_reg + 1'b1;
            psna_pkg::OP_REM_INIT:
            begin
                t_reg   <= lo_reg;
                rem_reg <= need_reg;
                idx_reg <= '0;
            end
            psna_pkg::OP_ACC_R:
            begin
                rem_reg <= (prior_cnt >= TW'(rem_reg)) ? '0
                                                       : PW'(TW'(rem_reg) - prior_cnt);
                idx_reg <= idx_reg + 1'b1;
            end
            psna_pkg::OP_SCAN_INIT:
                idx_reg <= '0;
            psna_pkg::OP_ACC_SC:
            begin
                if (drem == '0)
                begin
                    if (rem_reg == PW'(1))
                        ans_reg <= idx_reg + 1'b1;
                    rem_reg <= rem_reg - 1'b1;
                end
                idx_reg <= idx_reg + 1'b1;
            end
            psna_pkg::OP_FINISH:
            begin
                out_idx_reg <= psna_pkg::SIDX_W'(ans_reg);
                out_ovf_reg <= drop_reg;
            end
            default: ;
        endcase
    end

    assign st.triv     = (count_reg == '0) || (need_reg == '0);
    assign st.lo_lt_hi = lo_reg < hi_reg;
    assign st.idx_end  = idx_reg == count_reg;
    assign st.enough   = total_reg >= TW'(need_reg);
    assign st.rem_zero = rem_reg == '0;
    assign st.found    = found_reg;
    assign st.div_done = div_done;
    assign st.out_busy = out_valid_reg;

    assign rsp_valid        = out_valid_reg;
    assign rsp_server_index = out_idx_reg;
    assign rsp_overflow     = out_ovf_reg;
endmodule

// ----- hw/rtl/periodic_server_nth_assign.sv -----
// ----------------------------------------------------------------------------
// periodic_server_nth_assign
// Finds which periodic server takes the N-th job.
// ----------------------------------------------------------------------------
// Channel req (valid/ready) carries kind, period and position. A load beat
// (kind 0) appends one server period; loads past MAX_SERVERS are dropped
// and flagged. A query beat (kind 1) with servers loaded and a nonzero
// position starts a binary search over time 0 .. 2^TIME_BITS-1 in up to
// TIME_BITS steps; each step walks the stored servers (read, divider start,
// divide, add, check). The search is followed by a removal walk and, if jobs
// remain, a scan walk; req is not ready meanwhile.
// Channel rsp (valid/ready) returns server_index and overflow, one beat per
// query; the server list and overflow flag clear when the beat is produced.
// The result sits in an output register: loads and new queries are taken
// while it waits, and a later query holds its result until rsp drains.
// Reset clears the server count, the overflow flag and the response valid; the
// period memory is not cleared.
// ----------------------------------------------------------------------------
module periodic_server_nth_assign #(
    parameter int MAX_SERVERS = psna_pkg::MAX_SERVERS_DEF,
    parameter int TIME_BITS   = psna_pkg::TIME_BITS_DEF
) (
    input logic        clk,
    input logic        rst_n,
    psna_req_if.sink   req,
    psna_rsp_if.source rsp
);
    psna_pkg::cmd_t    cmd;
    psna_pkg::status_t st;

    psna_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_kind  (req.kind),
        .req_ready (req.ready),
        .st        (st),
        .cmd       (cmd)
    );

    psna_dp #(
        .MAX_SERVERS (MAX_SERVERS),
        .TIME_BITS   (TIME_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .st               (st),
        .req_period       (req.period),
        .req_position     (req.position),
        .rsp_valid        (rsp.valid),
        .rsp_ready        (rsp.ready),
        .rsp_server_index (rsp.server_index),
        .rsp_overflow     (rsp.overflow)
    );
endmodule

// ----- verif/tb_periodic_server_nth_assign.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_periodic_server_nth_assign
// Loads server periods, asks which server takes the N-th job and checks each
// answer against a built-in assignment predictor. Directed rows come first,
// then one full-list burst and then random load groups closed by queries,
// with bursty request traffic and a stalling response side.
// ----------------------------------------------------------------------------
module tb_periodic_server_nth_assign;
    localparam int PERIOD_W        = psna_pkg::PERIOD_W;
    localparam int POS_W           = psna_pkg::POS_W;
    localparam int SIDX_W          = psna_pkg::SIDX_W;
    localparam int MAX_SERVERS_DEF = psna_pkg::MAX_SERVERS_DEF;
    localparam int TIME_BITS_DEF   = psna_pkg::TIME_BITS_DEF;

    localparam bit KIND_LOAD  = 1'b0;
    localparam bit KIND_QUERY = 1'b1;
    localparam int NUM_ITEMS  = 1550;
    localparam longint CYCLE_LIMIT = 80_000_000;

    typedef struct {
        bit              kind;
        bit [PERIOD_W-1:0] per;
        bit [POS_W-1:0]    pos;
        bit              fixed;
        bit [SIDX_W-1:0]   idx;
        bit              ovf;
    } row_t;

    typedef struct {
        bit [SIDX_W-1:0] idx;
        bit              ovf;
    } answer_t;

    logic clk;
    logic rst_n;
    psna_req_if req ();
    psna_rsp_if rsp ();

    periodic_server_nth_assign u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // predictor state
    bit [PERIOD_W-1:0] period_mem [0:MAX_SERVERS_DEF-1];
    int                loaded;
    bit                dropped;
    answer_t           answer_q [$];

    bit                cur_fixed;
    answer_t           cur_answer;
    int                errors;
    longint            cycles;
    int                sent;
    int                burst_left;
    int                stall_mode;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic longint unsigned eff_period(int i);
        return (period_mem[i] == '0) ? 64'd1 : 64'(period_mem[i]);
    endfunction

    function automatic bit started_enough(longint unsigned t, longint unsigned need);
        longint unsigned total;
        total = 0;
        for (int i = 0; i < loaded; i++)
        begin
            total += t / eff_period(i) + 1;
            if (total >= need)
                return 1'b1;
        end
        return total >= need;
    endfunction

    function automatic bit [SIDX_W-1:0] server_for_job(longint unsigned need);
        longint unsigned lo, hi, mid, rem, p, prior;
        lo  = 0;
        hi  = (64'd1 << TIME_BITS_DEF) - 1;
        rem = need;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (started_enough(mid, need))
                hi = mid;
            else
                lo = mid + 1;
        end
        // drop the jobs started before the settled time
        for (int i = 0; i < loaded; i++)
        begin
            p     = eff_period(i);
            prior = (lo + p - 1) / p;
            rem   = (prior >= rem) ? 0 : rem - prior;
        end
        if (rem == 0)
            return '0;
        for (int i = 0; i < loaded; i++)
        begin
            if (lo % eff_period(i) == 0)
            begin
                if (rem == 1)
                    return SIDX_W'(i + 1);
                rem--;
            end
        end
        return '0;
    endfunction

    // predict on every accepted request beat
    always @(posedge clk)
    begin
        answer_t a;
        if (rst_n && req.valid && req.ready)
        begin
            if (req.kind == KIND_LOAD)
            begin
                if (loaded < MAX_SERVERS_DEF)
                begin
                    period_mem[loaded] = req.period;
                    loaded++;
                end
                else
                    dropped = 1'b1;
            end
            else
            begin
                a.idx = '0;
                if (loaded != 0 && req.position != 0)
                    a.idx = server_for_job(64'(req.position));
                a.ovf = dropped;
                if (cur_fixed)
                    a = cur_answer;
                answer_q.push_back(a);
                loaded  = 0;
                dropped = 1'b0;
            end
        end
    end

    // compare every accepted response beat
    always @(posedge clk)
    begin
        answer_t a;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (answer_q.size() == 0)
            begin
                $error("server_index: no answer expected, got %0d", rsp.server_index);
                errors++;
            end
            else
            begin
                a = answer_q.pop_front();
                if (rsp.server_index !== a.idx)
                begin
                    $error("server_index: expected %0d, actual %0d", a.idx, rsp.server_index);
                    errors++;
                end
                if (rsp.overflow !== a.ovf)
                begin
                    $error("overflow: expected %0d, actual %0d", a.ovf, rsp.overflow);
                    errors++;
                end
            end
        end
    end

    // response side stalls on its own pattern
    always @(negedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: rsp.ready <= 1'b1;
            1: rsp.ready <= ($urandom_range(0, 3) != 0);
            default: rsp.ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("periodic_server_nth_assign regression: fail");
            $finish;
        end
    end

    task automatic send(bit kind, bit [PERIOD_W-1:0] per, bit [POS_W-1:0] pos,
                        bit fixed = 1'b0, bit [SIDX_W-1:0] idx = '0, bit ovf = 1'b0);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
        burst_left--;
        repeat (gap)
        begin
            @(negedge clk);
            req.valid <= 1'b0;
        end
        @(negedge clk);
        req.valid    <= 1'b1;
        req.kind     <= kind;
        req.period   <= per;
        req.position <= pos;
        cur_fixed         = fixed;
        cur_answer.idx    = idx;
        cur_answer.ovf    = ovf;
        do
            @(posedge clk);
        while (!req.ready);
        sent++;
    endtask

    function automatic bit [PERIOD_W-1:0] rand_period();
        case ($urandom_range(0, 5))
            0: return PERIOD_W'($urandom_range(0, 20'hFFFFF));
            1: return PERIOD_W'(20'hFFFFF - $urandom_range(0, 3));
            2: return '0;
            default: return PERIOD_W'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic bit [POS_W-1:0] rand_position();
        case ($urandom_range(0, 7))
            0: return $urandom();
            1: return 32'hFFFF_FFFF - $urandom_range(0, 7);
            2: return '0;
            default: return $urandom_range(1, 60);
        endcase
    endfunction

    row_t rows [$];

    initial
    begin
        int n;
        req.valid    = 1'b0;
        req.kind     = KIND_LOAD;
        req.period   = '0;
        req.position = '0;
        rsp.ready    = 1'b1;
        rst_n        = 1'b0;
        loaded       = 0;
        dropped      = 1'b0;
        errors       = 0;
        cycles       = 0;
        sent         = 0;
        burst_left   = 0;
        stall_mode   = 0;
        cur_fixed    = 1'b0;

        rows = '{
            '{KIND_QUERY, 20'h0,     32'd5,          1, 11'd0, 0},
            '{KIND_LOAD,  20'd1,     32'h0,          0, 11'd0, 0},
            '{KIND_QUERY, 20'h0,     32'd1,          1, 11'd1, 0},
            '{KIND_LOAD,  20'd0,     32'hFFFF_FFFF,  0, 11'd0, 0},
            '{KIND_QUERY, 20'hFFFFF, 32'd0,          1, 11'd0, 0},
            '{KIND_LOAD,  20'd3,     32'h0,          0, 11'd0, 0},
            '{KIND_LOAD,  20'd5,     32'h0,          0, 11'd0, 0},
            '{KIND_LOAD,  20'hFFFFF, 32'h0,          0, 11'd0, 0},
            '{KIND_QUERY, 20'h0,     32'd7,          0, 11'd0, 0},
            '{KIND_LOAD,  20'd2,     32'h0,          0, 11'd0, 0},
            '{KIND_LOAD,  20'd2,     32'h0,          0, 11'd0, 0},
            '{KIND_QUERY, 20'h0,     32'd2,          1, 11'd2, 0},
            '{KIND_LOAD,  20'hFFFFF, 32'h0,          0, 11'd0, 0},
            '{KIND_QUERY, 20'h0,     32'hFFFF_FFFF,  0, 11'd0, 0},
            '{KIND_LOAD,  20'd1,     32'h0,          0, 11'd0, 0},
            '{KIND_LOAD,  20'hFFFFF, 32'h0,          0, 11'd0, 0},
            '{KIND_QUERY, 20'h0,     32'h8000_0000,  0, 11'd0, 0},
            '{KIND_LOAD,  20'd7,     32'h0,          0, 11'd0, 0},
            '{KIND_QUERY, 20'h0,     32'd1,          1, 11'd1, 0}
        };

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[i])
            send(rows[i].kind, rows[i].per, rows[i].pos, rows[i].fixed, rows[i].idx, rows[i].ovf);

        // fill past capacity; the closing query reports the dropped loads
        for (int i = 0; i < MAX_SERVERS_DEF + 2; i++)
            send(KIND_LOAD, (i % 2) ? 20'hFFFFF : 20'($urandom_range(1, 50)), $urandom());
        send(KIND_QUERY, PERIOD_W'($urandom_range(0, 20'hFFFFF)), $urandom_range(1, 4000));

        while (sent < NUM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0: send(KIND_QUERY, PERIOD_W'($urandom_range(0, 20'hFFFFF)), rand_position());
                default:
                begin
                    n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16)
                                                    : $urandom_range(1, 5);
                    repeat (n) send(KIND_LOAD, rand_period(), $urandom());
                    send(KIND_QUERY, PERIOD_W'($urandom_range(0, 20'hFFFFF)),
                         rand_position());
                end
            endcase
        end
        @(negedge clk);
        req.valid <= 1'b0;

        while (answer_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        if (errors == 0)
            $display("periodic_server_nth_assign regression: pass");
        else
            $display("periodic_server_nth_assign regression: fail");
        $finish;
    end
endmodule
